@@ rtl/lhgv_pkg.sv @@
// Shared types and constants of the load header group validator.
// Used by the front, queue, back and top-level modules; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package lhgv_pkg;

  localparam int unsigned GROUP_SLOTS        = 8;
  localparam int unsigned SEGMENT_PARAGRAPHS = 4096;
  localparam int unsigned SLOT_W = (GROUP_SLOTS > 1) ? $clog2(GROUP_SLOTS) : 1;
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(GROUP_SLOTS - 1);

  localparam int unsigned FORM_W   = 8;
  localparam int unsigned WORD_W   = 16;
  localparam int unsigned FLEN_W   = 24;
  localparam int unsigned GRANT_W  = 13;
  localparam int unsigned OFFS_W   = 20;
  localparam int unsigned ENTRY_W  = 9;
  localparam int unsigned FORMS    = 8;

  localparam logic [FORM_W-1:0] FORM_NONE = 8'd0;
  localparam logic [FORM_W-1:0] FORM_MAX  = 8'd8;

  localparam logic [WORD_W-1:0] SEG_PARAS    = WORD_W'(SEGMENT_PARAGRAPHS);
  localparam logic [OFFS_W-1:0] HEADER_BYTES = OFFS_W'(128);
  localparam logic [ENTRY_W-1:0] ENTRY_CODE_ONLY = 9'h100;

  localparam logic [FORMS-1:0] MASK_CODE  = 8'h01;
  localparam logic [FORMS-1:0] MASK_DATA  = 8'h02;
  localparam logic [FORMS-1:0] MASK_EXTRA = 8'h0c;
  localparam logic [FORMS-1:0] MASK_AUX   = 8'hf0;

  localparam int unsigned S_DATA_W = 96;
  localparam int unsigned M_DATA_W = 72;
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_TRUNC  = 3'd1,
    ST_FORM   = 3'd2,
    ST_DUP    = 3'd3,
    ST_BASE   = 3'd4,
    ST_BIG    = 3'd5,
    ST_NOCODE = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    MODEL_CODE_ONLY = 2'd0,
    MODEL_SMALL     = 2'd1,
    MODEL_COMPACT   = 2'd2,
    MODEL_LARGE     = 2'd3
  } model_t;

  // Descriptor after classification by the front end.
  typedef struct packed {
    logic               short_file;
    logic               absent;
    logic               bad_form;
    logic [FORMS-1:0]   form_bit;
    logic               base_set;
    logic               too_big;
    logic [GRANT_W-1:0] granted;
    logic [OFFS_W-1:0]  advance;
    logic [FLEN_W-1:0]  file_length;
  } item_t;

  typedef struct packed {
    logic [OFFS_W-1:0]  bytes_needed;
    logic [ENTRY_W-1:0] entry_offset;
    model_t             model;
    status_t            status;
    logic [OFFS_W-1:0]  image_offset;
    logic [GRANT_W-1:0] granted_paragraphs;
  } result_t;

endpackage
`default_nettype wire

@@ rtl/lhgv_front.sv @@
// Front end: accepts descriptor transactions, decodes them and computes the
// stateless checks and the grant. Depends on lhgv_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lhgv_front import lhgv_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  input  wire logic [S_DATA_W-1:0] s_tdata,
  output logic                     q_valid,
  input  wire logic                q_ready,
  output item_t                    q_item
);

  logic [FORM_W-1:0] form;
  logic [WORD_W-1:0] len, base, mn, mx;
  logic [FLEN_W-1:0] flen;
  logic [FORM_W-1:0] form_m1;
  logic [WORD_W-1:0] g_n, g_want;
  item_t             cls;
  logic              valid;
  item_t             item;

  assign form = s_tdata[7:0];
  assign len  = s_tdata[23:8];
  assign base = s_tdata[39:24];
  assign mn   = s_tdata[55:40];
  assign mx   = s_tdata[71:56];
  assign flen = s_tdata[95:72];

  always_comb begin
    // Grant: larger of image and minimum, at least one, grown to the
    // wanted maximum and capped at a full segment.
    g_n = (len > mn) ? len : mn;
    if (g_n == '0) begin
      g_n = WORD_W'(1);
    end
    if (mx == '0) begin
      g_want = SEG_PARAS;
    end else if (mx > SEG_PARAS) begin
      g_want = SEG_PARAS;
    end else begin
      g_want = mx;
    end
    if (g_want > g_n) begin
      g_n = g_want;
    end
    if (g_n > SEG_PARAS) begin
      g_n = SEG_PARAS;
    end

    form_m1          = form - FORM_W'(1);
    cls.short_file   = flen < FLEN_W'(HEADER_BYTES);
    cls.absent       = form == FORM_NONE;
    cls.bad_form     = form > FORM_MAX;
    cls.form_bit     = FORMS'(1) << form_m1[$clog2(FORMS)-1:0];
    cls.base_set     = base != '0;
    cls.too_big      = (len > SEG_PARAS) || (mn > SEG_PARAS) || (mx > SEG_PARAS);
    cls.granted      = g_n[GRANT_W-1:0];
    cls.advance      = {len, 4'b0000};
    cls.file_length  = flen;
  end

  assign s_tready = !valid || q_ready;
  assign q_valid  = valid;
  assign q_item   = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s_tready) begin
      valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item <= cls;
    end
  end

endmodule
`default_nettype wire

@@ rtl/lhgv_queue.sv @@
// Two-entry queue of classified descriptors between front and back end.
// Depends on lhgv_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lhgv_queue import lhgv_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire item_t in_item,
  output logic       out_valid,
  input  wire logic  out_ready,
  output item_t      out_item
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

  item_t                       entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]            wr_ptr, rd_ptr;
  logic [$clog2(QUEUE_DEPTH+1)-1:0] count;
  logic                        push, pop;

  assign in_ready  = count < ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH);
  assign out_valid = count != '0;
  assign out_item  = entries[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= in_item;
    end
  end

endmodule
`default_nettype wire

@@ rtl/lhgv_back.sv @@
// Back end: applies classified descriptors to the header state (slot count,
// forms seen, running offset, latched refusal) and registers the result.
// Depends on lhgv_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lhgv_back import lhgv_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire item_t in_item,
  output logic       out_valid,
  input  wire logic  out_ready,
  output result_t    out_result,
  output logic       out_last
);

  logic [SLOT_W-1:0] slot_count;
  logic [FORMS-1:0]  forms_seen;
  logic [OFFS_W-1:0] running_offset;
  status_t           refusal_code;
  logic              refused;

  logic [FORMS-1:0]  forms_next;
  logic [OFFS_W-1:0] offset_next;
  status_t           code_next;
  logic              refused_next;
  logic              is_last;
  result_t           res;
  logic              fire;

  assign in_ready = !out_valid || out_ready;
  assign fire     = in_valid && in_ready;
  assign is_last  = slot_count == SLOT_LAST;

  always_comb begin
    forms_next   = forms_seen;
    offset_next  = running_offset;
    code_next    = refusal_code;
    refused_next = refused;
    res          = '0;
    res.status   = ST_OK;
    res.model    = MODEL_CODE_ONLY;
    res.image_offset = running_offset;

    if (!refused && in_item.short_file) begin
      refused_next = 1'b1;
      code_next    = ST_TRUNC;
    end else if (!refused && !in_item.absent) begin
      priority if (in_item.bad_form) begin
        refused_next = 1'b1;
        code_next    = ST_FORM;
      end else if ((forms_seen & in_item.form_bit) != '0) begin
        refused_next = 1'b1;
        code_next    = ST_DUP;
      end else begin
        // Later refusals still mark the form as seen.
        forms_next = forms_seen | in_item.form_bit;
        priority if (in_item.base_set) begin
          refused_next = 1'b1;
          code_next    = ST_BASE;
        end else if (in_item.too_big) begin
          refused_next = 1'b1;
          code_next    = ST_BIG;
        end else begin
          res.granted_paragraphs = in_item.granted;
          offset_next = running_offset + in_item.advance;
        end
      end
    end

    if (is_last) begin
      res.bytes_needed = offset_next;
      if (!refused_next) begin
        if ((forms_next & MASK_CODE) == '0) begin
          refused_next = 1'b1;
          code_next    = ST_NOCODE;
        end else if (in_item.file_length < FLEN_W'(offset_next)) begin
          refused_next = 1'b1;
          code_next    = ST_TRUNC;
        end
      end
      if (refused_next) begin
        res.status = code_next;
      end else begin
        priority if ((forms_next & MASK_AUX) != '0) begin
          res.model = MODEL_LARGE;
        end else if ((forms_next & MASK_EXTRA) != '0) begin
          res.model = MODEL_COMPACT;
        end else if ((forms_next & MASK_DATA) != '0) begin
          res.model = MODEL_SMALL;
        end else begin
          res.model        = MODEL_CODE_ONLY;
          res.entry_offset = ENTRY_CODE_ONLY;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_count     <= '0;
      forms_seen     <= '0;
      running_offset <= HEADER_BYTES;
      refusal_code   <= ST_OK;
      refused        <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (in_ready) begin
        out_valid <= in_valid;
      end
      if (fire) begin
        if (is_last) begin
          // A finished header leaves the state ready for the next one.
          slot_count     <= '0;
          forms_seen     <= '0;
          running_offset <= HEADER_BYTES;
          refusal_code   <= ST_OK;
          refused        <= 1'b0;
        end else begin
          slot_count     <= slot_count + SLOT_W'(1);
          forms_seen     <= forms_next;
          running_offset <= offset_next;
          refusal_code   <= code_next;
          refused        <= refused_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_result <= res;
      out_last   <= is_last;
    end
  end

endmodule
`default_nettype wire

@@ rtl/load_header_group_validator.sv @@
// Top level of the load header group validator: front end, queue, back end.
// Depends on lhgv_pkg, lhgv_front, lhgv_queue and lhgv_back.
`timescale 1ns / 1ps
`default_nettype none
// The block takes the group descriptors of an executable load header, eight
// to a header, and returns one result transaction per descriptor with the
// granted paragraphs and image offset; the eighth one carries tlast and the
// header summary (status, memory model, entry offset, bytes needed). It
// sustains one descriptor per clock cycle while m_tready is high. A result
// passes through the front-end decode register, the two-entry queue and the
// back-end output register. The back end updates the header state once per
// cycle while it accepts descriptors, and that loop of one compare chain and
// one 20-bit add sets the rate.
module load_header_group_validator import lhgv_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  // form[7:0], image_paragraphs[23:8], absolute_base[39:24],
  // min_paragraphs[55:40], max_paragraphs[71:56], file_length[95:72]
  input  wire logic [S_DATA_W-1:0] s_tdata,
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  // granted_paragraphs[12:0], image_offset[32:13], status[35:33],
  // model[37:36], entry_offset[46:38], bytes_needed[66:47], zero[71:67]
  output logic [M_DATA_W-1:0]      m_tdata,
  output logic                     m_tlast
);

  logic    f_valid, f_ready;
  item_t   f_item;
  logic    b_valid, b_ready;
  item_t   b_item;
  result_t result;

  lhgv_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_valid  (f_valid),
    .q_ready  (f_ready),
    .q_item   (f_item)
  );

  lhgv_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_item   (f_item),
    .out_valid (b_valid),
    .out_ready (b_ready),
    .out_item  (b_item)
  );

  lhgv_back u_back (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (b_valid),
    .in_ready   (b_ready),
    .in_item    (b_item),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_result (result),
    .out_last   (m_tlast)
  );

  assign m_tdata = {5'b00000, result.bytes_needed, result.entry_offset, result.model,
                    result.status, result.image_offset, result.granted_paragraphs};

endmodule
`default_nettype wire
